/* rtl/core/isarm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isarm_pkg
// Shared types, widths and constants of the ICMP scan address-run metrics unit.
// ----------------------------------------------------------------------------
package isarm_pkg;

    localparam int ADDR_W      = 32;
    localparam int SUBNET_W    = 24;
    localparam int ICMP_W      = 8;
    localparam int RUN_W       = 8;
    localparam int CNT_W       = 25;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (3 * CNT_W + 2 * RUN_W);

    localparam longint unsigned MAX_EVENT_FLOWS_DEF = 64'd16777216;
    localparam longint unsigned CNT_FIELD_MAX       = 64'h1FF_FFFF;

    localparam logic [ADDR_W-1:0] SUBNET_MASK = 32'hFFFF_FF00;

    localparam logic [ICMP_W-1:0] ICMP_ECHO_REQ      = 8'd8;
    localparam logic [ICMP_W-1:0] ICMP_TIMESTAMP_REQ = 8'd13;
    localparam logic [ICMP_W-1:0] ICMP_INFO_REQ      = 8'd15;
    localparam logic [ICMP_W-1:0] ICMP_MASK_REQ      = 8'd17;
    localparam logic [ICMP_W-1:0] ICMP_CODE_NONE     = 8'd0;

    typedef struct packed {
        logic [ADDR_W-1:0] dst_addr;
        logic [ICMP_W-1:0] icmp_type;
        logic [ICMP_W-1:0] icmp_code;
        logic              last;
    } flow_t;

    typedef struct packed {
        logic [CNT_W-1:0] flow_count;
        logic [CNT_W-1:0] echo_count;
        logic [RUN_W-1:0] subnet_addr_count_max;
        logic [RUN_W-1:0] addr_run_max;
        logic [CNT_W-1:0] subnet_run_max;
    } result_t;

    typedef struct packed {
        logic take;
        logic load;
    } core_ctl_t;

    function automatic logic [RUN_W-1:0] max_run(input logic [RUN_W-1:0] a,
                                                 input logic [RUN_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [CNT_W-1:0] max_cnt(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] cap);
        return (v < cap) ? v + 1'b1 : cap;
    endfunction

endpackage

/* rtl/core/isarm_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isarm_in_reg
// Input register: holds one flow transaction until the core takes it.
// ----------------------------------------------------------------------------
module isarm_in_reg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [isarm_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                               s_tlast,
    input  logic                               take,
    output logic                               item_valid,
    output isarm_pkg::flow_t                   item
);
    import isarm_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    flow_t item_reg;
    logic  load;

    assign s_tready   = !valid_reg || take;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.dst_addr  <= s_tdata[ADDR_W-1:0];
            item_reg.icmp_type <= s_tdata[ADDR_W+ICMP_W-1:ADDR_W];
            item_reg.icmp_code <= s_tdata[ADDR_W+2*ICMP_W-1:ADDR_W+ICMP_W];
            item_reg.last      <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/core/isarm_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isarm_core
// Metrics state and the per-flow update: pairs each flow with its predecessor
// and flushes the event into a result on the last flow.
// ----------------------------------------------------------------------------
module isarm_core
#(
    parameter longint unsigned MAX_EVENT_FLOWS = isarm_pkg::MAX_EVENT_FLOWS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  isarm_pkg::flow_t      item,
    input  logic                  out_ready,
    output isarm_pkg::core_ctl_t  ctl,
    output isarm_pkg::result_t    result
);
    import isarm_pkg::*;

    localparam longint unsigned CAP_L =
        (MAX_EVENT_FLOWS < CNT_FIELD_MAX) ? MAX_EVENT_FLOWS : CNT_FIELD_MAX;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_L);

    logic [ADDR_W-1:0] prev_addr_reg,          prev_addr_next;
    logic              have_prev_reg,          have_prev_next;
    logic [RUN_W-1:0]  addr_run_reg,           addr_run_next;
    logic [RUN_W-1:0]  best_addr_run_reg,      best_addr_run_next;
    logic [RUN_W-1:0]  published_addr_run_reg, published_addr_run_next;
    logic [CNT_W-1:0]  subnet_run_reg,         subnet_run_next;
    logic [CNT_W-1:0]  best_subnet_run_reg,    best_subnet_run_next;
    logic [RUN_W-1:0]  subnet_addrs_reg,       subnet_addrs_next;
    logic [RUN_W-1:0]  best_subnet_addrs_reg,  best_subnet_addrs_next;
    logic [CNT_W-1:0]  echo_total_reg,         echo_total_next;
    logic [CNT_W-1:0]  flow_total_reg,         flow_total_next;

    logic [SUBNET_W-1:0] sub_prev;
    logic [SUBNET_W-1:0] sub_cur;
    logic                same_subnet;
    logic                next_subnet;
    logic                consec_addr;
    logic                is_echo;
    logic                take;

    logic [RUN_W-1:0]  p_addr_run;
    logic [RUN_W-1:0]  p_best_addr_run;
    logic [RUN_W-1:0]  p_published;
    logic [CNT_W-1:0]  p_subnet_run;
    logic [CNT_W-1:0]  p_best_subnet_run;
    logic [RUN_W-1:0]  p_subnet_addrs;
    logic [RUN_W-1:0]  p_best_subnet_addrs;

    assign take = item_valid && (!item.last || out_ready);
    assign ctl.take = take;
    assign ctl.load = take && item.last;

    assign sub_prev    = prev_addr_reg[ADDR_W-1:ADDR_W-SUBNET_W];
    assign sub_cur     = item.dst_addr[ADDR_W-1:ADDR_W-SUBNET_W];
    assign same_subnet = (prev_addr_reg & SUBNET_MASK) == (item.dst_addr & SUBNET_MASK);
    assign next_subnet = (sub_cur - sub_prev) == SUBNET_W'(1);
    assign consec_addr = (item.dst_addr - prev_addr_reg) == ADDR_W'(1);
    assign is_echo     = ((item.icmp_type == ICMP_ECHO_REQ)
                       || (item.icmp_type == ICMP_TIMESTAMP_REQ)
                       || (item.icmp_type == ICMP_INFO_REQ)
                       || (item.icmp_type == ICMP_MASK_REQ))
                       && (item.icmp_code == ICMP_CODE_NONE);

    // pair the flow with its predecessor
    always_comb
    begin
        p_addr_run          = addr_run_reg;
        p_best_addr_run     = best_addr_run_reg;
        p_published         = published_addr_run_reg;
        p_subnet_run        = subnet_run_reg;
        p_best_subnet_run   = best_subnet_run_reg;
        p_subnet_addrs      = subnet_addrs_reg;
        p_best_subnet_addrs = best_subnet_addrs_reg;
        if (have_prev_reg)
        begin
            if (same_subnet)
            begin
                if (item.dst_addr != prev_addr_reg)
                begin
                    p_subnet_addrs = subnet_addrs_reg + 1'b1;
                    if (consec_addr)
                    begin
                        p_addr_run = addr_run_reg + 1'b1;
                    end
                    else
                    begin
                        p_best_addr_run = max_run(best_addr_run_reg, addr_run_reg);
                        p_addr_run      = RUN_W'(1);
                    end
                end
            end
            else
            begin
                if (next_subnet)
                begin
                    p_subnet_run = sat_inc(subnet_run_reg, COUNT_CAP);
                end
                else
                begin
                    p_best_subnet_run = max_cnt(best_subnet_run_reg, subnet_run_reg);
                    p_subnet_run      = CNT_W'(1);
                end
                p_published         = max_run(published_addr_run_reg, best_addr_run_reg);
                p_best_subnet_addrs = max_run(best_subnet_addrs_reg, subnet_addrs_reg);
                p_subnet_addrs      = RUN_W'(1);
            end
        end
    end

    // flush the event into the result
    always_comb
    begin
        result.subnet_run_max        = max_cnt(p_best_subnet_run, p_subnet_run);
        result.addr_run_max          = max_run(p_published, p_best_addr_run);
        result.subnet_addr_count_max = max_run(p_best_subnet_addrs, p_subnet_addrs);
        result.echo_count            = echo_total_next;
        result.flow_count            = flow_total_next;
    end

    assign flow_total_next = sat_inc(flow_total_reg, COUNT_CAP);
    assign echo_total_next = is_echo ? sat_inc(echo_total_reg, COUNT_CAP) : echo_total_reg;

    always_comb
    begin
        prev_addr_next          = item.dst_addr;
        have_prev_next          = 1'b1;
        addr_run_next           = p_addr_run;
        best_addr_run_next      = p_best_addr_run;
        published_addr_run_next = p_published;
        subnet_run_next         = p_subnet_run;
        best_subnet_run_next    = p_best_subnet_run;
        subnet_addrs_next       = p_subnet_addrs;
        best_subnet_addrs_next  = p_best_subnet_addrs;
        if (item.last)
        begin
            prev_addr_next          = '0;
            have_prev_next          = 1'b0;
            addr_run_next           = RUN_W'(1);
            best_addr_run_next      = RUN_W'(1);
            published_addr_run_next = '0;
            subnet_run_next         = CNT_W'(1);
            best_subnet_run_next    = CNT_W'(1);
            subnet_addrs_next       = RUN_W'(1);
            best_subnet_addrs_next  = RUN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_addr_reg          <= '0;
            have_prev_reg          <= 1'b0;
            addr_run_reg           <= RUN_W'(1);
            best_addr_run_reg      <= RUN_W'(1);
            published_addr_run_reg <= '0;
            subnet_run_reg         <= CNT_W'(1);
            best_subnet_run_reg    <= CNT_W'(1);
            subnet_addrs_reg       <= RUN_W'(1);
            best_subnet_addrs_reg  <= RUN_W'(1);
            echo_total_reg         <= '0;
            flow_total_reg         <= '0;
        end
        else if (take)
        begin
            prev_addr_reg          <= prev_addr_next;
            have_prev_reg          <= have_prev_next;
            addr_run_reg           <= addr_run_next;
            best_addr_run_reg      <= best_addr_run_next;
            published_addr_run_reg <= published_addr_run_next;
            subnet_run_reg         <= subnet_run_next;
            best_subnet_run_reg    <= best_subnet_run_next;
            subnet_addrs_reg       <= subnet_addrs_next;
            best_subnet_addrs_reg  <= best_subnet_addrs_next;
            echo_total_reg         <= item.last ? '0 : echo_total_next;
            flow_total_reg         <= item.last ? '0 : flow_total_next;
        end
    end

`ifndef SYNTH
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.last |=> (flow_total_reg == '0) && !have_prev_reg)
        else $error("event state not cleared after last flow");

    a_flow_counted: assert property (@(posedge clk) disable iff (!rst_n)
        take && !item.last |=> have_prev_reg && (flow_total_reg != '0))
        else $error("accepted flow not recorded");

    a_echo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (echo_total_reg <= flow_total_reg) && (flow_total_reg <= COUNT_CAP))
        else $error("echo or flow total out of range");

    a_subnet_run_min: assert property (@(posedge clk) disable iff (!rst_n)
        (best_subnet_run_reg != '0) && (subnet_run_reg != '0))
        else $error("subnet run dropped to zero");
`endif

endmodule

/* rtl/core/isarm_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isarm_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module isarm_out_reg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  isarm_pkg::core_ctl_t               ctl,
    input  isarm_pkg::result_t                 result,
    output logic                               out_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [isarm_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import isarm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_ready  = !valid_reg || m_tready;
    assign valid_next = ctl.load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {OUT_PAD_W'(0), result_reg};

endmodule

/* rtl/core/icmp_scan_address_run_metrics_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_scan_address_run_metrics_unit
// Address-run and subnet-run metrics over the sorted ICMP flows of one event.
//
//   Channel   Dir  Signals                      Transaction
//   s_axis    in   s_tvalid s_tready s_tdata    one flow, s_tlast ends event
//                  s_tlast
//   m_axis    out  m_tvalid m_tready m_tdata    one metrics result per event
//
// One flow per cycle sustained while no last flow waits on m_axis; a flow
// passes the input register, which feeds the state and result registers.
// A result appears on m_axis the cycle after its last flow is processed.
// rst_n clears all metrics state and the valid flags of both registers.
// A last flow waits in the input register while the result register is full
// and not being taken; other flows never wait on m_axis.
// ----------------------------------------------------------------------------
module icmp_scan_address_run_metrics_unit
#(
    parameter longint unsigned MAX_EVENT_FLOWS = isarm_pkg::MAX_EVENT_FLOWS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] dst_addr, [39:32] icmp_type, [47:40] icmp_code
    input  logic [isarm_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [24:0] subnet_run_max, [32:25] addr_run_max, [40:33] subnet_addr_count_max,
    // [65:41] echo_count, [90:66] flow_count, [95:91] zero
    output logic [isarm_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import isarm_pkg::*;

    logic      item_valid;
    flow_t     item;
    core_ctl_t ctl;
    result_t   result;
    logic      out_ready;

    isarm_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (ctl.take),
        .item_valid (item_valid),
        .item       (item)
    );

    isarm_core
    #(
        .MAX_EVENT_FLOWS (MAX_EVENT_FLOWS)
    )
    u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .ctl        (ctl),
        .result     (result)
    );

    isarm_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .result    (result),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* tb/icmp_scan_metrics_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_scan_metrics_checker
// Watches both stream channels of the ICMP scan address-run metrics unit,
// folds every accepted flow into its own copy of the event metrics and
// compares each emitted result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module icmp_scan_metrics_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [isarm_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [isarm_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                                mismatches,
    output int                                pending,
    output int                                flows_seen,
    output int                                results_seen
);
    import isarm_pkg::*;

    localparam logic [CNT_W-1:0] COUNT_CAP = (MAX_EVENT_FLOWS_DEF < CNT_FIELD_MAX) ?
                                             CNT_W'(MAX_EVENT_FLOWS_DEF) : CNT_W'(CNT_FIELD_MAX);

    logic [ADDR_W-1:0] prev_addr;
    logic              have_prev;
    logic [RUN_W-1:0]  addr_run;
    logic [RUN_W-1:0]  best_addr_run;
    logic [RUN_W-1:0]  published_run;
    logic [RUN_W-1:0]  subnet_addrs;
    logic [RUN_W-1:0]  best_subnet_addrs;
    logic [CNT_W-1:0]  subnet_run;
    logic [CNT_W-1:0]  best_subnet_run;
    logic [CNT_W-1:0]  echo_total;
    logic [CNT_W-1:0]  flow_total;

    result_t due_metrics[$];

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v < COUNT_CAP) ? v + 1'b1 : COUNT_CAP;
    endfunction

    task automatic restart_event();
        prev_addr         = '0;
        have_prev         = 1'b0;
        addr_run          = 8'd1;
        best_addr_run     = 8'd1;
        published_run     = 8'd0;
        subnet_run        = 25'd1;
        best_subnet_run   = 25'd1;
        subnet_addrs      = 8'd1;
        best_subnet_addrs = 8'd1;
        echo_total        = '0;
        flow_total        = '0;
    endtask

    task automatic close_subnet(input logic next_subnet);
        if (next_subnet)
        begin
            subnet_run = bump(subnet_run);
        end
        else
        begin
            if (subnet_run > best_subnet_run)
                best_subnet_run = subnet_run;
            subnet_run = 25'd1;
        end
        if (best_addr_run > published_run)
            published_run = best_addr_run;
        if (subnet_addrs > best_subnet_addrs)
            best_subnet_addrs = subnet_addrs;
        subnet_addrs = 8'd1;
    endtask

    task automatic fold_flow(input logic [ADDR_W-1:0] addr, input logic [ICMP_W-1:0] kind,
                             input logic [ICMP_W-1:0] code, input logic last);
        logic [ADDR_W-1:0] sa;
        logic [ADDR_W-1:0] sb;
        result_t           res;
        flow_total = bump(flow_total);
        if ((kind inside {ICMP_ECHO_REQ, ICMP_TIMESTAMP_REQ, ICMP_INFO_REQ, ICMP_MASK_REQ})
            && code == ICMP_CODE_NONE)
            echo_total = bump(echo_total);
        if (have_prev)
        begin
            sa = prev_addr & SUBNET_MASK;
            sb = addr & SUBNET_MASK;
            if (sa == sb)
            begin
                if (addr != prev_addr)
                begin
                    subnet_addrs = subnet_addrs + 1'b1;
                    if (addr - prev_addr == 32'd1)
                    begin
                        addr_run = addr_run + 1'b1;
                    end
                    else
                    begin
                        if (addr_run > best_addr_run)
                            best_addr_run = addr_run;
                        addr_run = 8'd1;
                    end
                end
            end
            else
            begin
                close_subnet(((sb - sa) >> 8) == 32'd1);
            end
        end
        prev_addr = addr;
        have_prev = 1'b1;
        if (last)
        begin
            close_subnet(1'b0);
            res.subnet_run_max        = best_subnet_run;
            res.addr_run_max          = published_run;
            res.subnet_addr_count_max = best_subnet_addrs;
            res.echo_count            = echo_total;
            res.flow_count            = flow_total;
            due_metrics.push_back(res);
            restart_event();
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("checker: result %0d: %s", results_seen, what);
    endtask

    initial
    begin
        mismatches   = 0;
        pending      = 0;
        flows_seen   = 0;
        results_seen = 0;
        restart_event();
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            restart_event();
            due_metrics.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[3*CNT_W+2*RUN_W-1:0]);
                if (due_metrics.size() == 0)
                begin
                    report_mismatch("result with none due");
                end
                else
                begin
                    want = due_metrics.pop_front();
                    if (got.subnet_run_max !== want.subnet_run_max)
                        report_mismatch($sformatf("subnet_run_max %0d, want %0d",
                                                  got.subnet_run_max, want.subnet_run_max));
                    if (got.addr_run_max !== want.addr_run_max)
                        report_mismatch($sformatf("addr_run_max %0d, want %0d",
                                                  got.addr_run_max, want.addr_run_max));
                    if (got.subnet_addr_count_max !== want.subnet_addr_count_max)
                        report_mismatch($sformatf("subnet_addr_count_max %0d, want %0d",
                                                  got.subnet_addr_count_max,
                                                  want.subnet_addr_count_max));
                    if (got.echo_count !== want.echo_count)
                        report_mismatch($sformatf("echo_count %0d, want %0d",
                                                  got.echo_count, want.echo_count));
                    if (got.flow_count !== want.flow_count)
                        report_mismatch($sformatf("flow_count %0d, want %0d",
                                                  got.flow_count, want.flow_count));
                end
                if (m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0)
                    report_mismatch("padding bits not zero");
                results_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                flows_seen++;
                fold_flow(s_tdata[31:0], s_tdata[39:32], s_tdata[47:40], s_tlast);
            end
            pending = due_metrics.size();
        end
    end

endmodule

/* tb/icmp_scan_address_run_metrics_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_scan_address_run_metrics_unit_tb
// Drives sorted and unsorted ICMP flow events into the metrics unit with
// random gaps and back-pressure, including one long output hold-off, and
// takes the verdict from the checker that runs beside the unit.
// ----------------------------------------------------------------------------
module icmp_scan_address_run_metrics_unit_tb;
    import isarm_pkg::*;

    localparam int FLOW_TARGET = 1700;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [31:0] dst_addr, [39:32] icmp_type, [47:40] icmp_code
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [24:0] subnet_run_max, [32:25] addr_run_max, [40:33] subnet_addr_count_max,
    // [65:41] echo_count, [90:66] flow_count, [95:91] zero
    logic [OUT_TDATA_W-1:0] m_tdata;

    int mismatches;
    int pending;
    int flows_seen;
    int results_seen;
    int cycles  = 0;
    int sent    = 0;
    int sweeps  = 0;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;

    icmp_scan_address_run_metrics_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    icmp_scan_metrics_checker checker_i
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .pending      (pending),
        .flows_seen   (flows_seen),
        .results_seen (results_seen)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_flow(input logic [ADDR_W-1:0] addr, input logic [ICMP_W-1:0] kind,
                             input logic [ICMP_W-1:0] code, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {code, kind, addr};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    task automatic send_random_flow(input logic [ADDR_W-1:0] addr, input logic last);
        logic [ICMP_W-1:0] kind;
        logic [ICMP_W-1:0] code;
        if ($urandom_range(0, 9) < 5)
        begin
            case ($urandom_range(0, 3))
                0:       kind = ICMP_ECHO_REQ;
                1:       kind = ICMP_TIMESTAMP_REQ;
                2:       kind = ICMP_INFO_REQ;
                default: kind = ICMP_MASK_REQ;
            endcase
            code = ($urandom_range(0, 3) == 0) ? ICMP_W'($urandom) : ICMP_CODE_NONE;
        end
        else
        begin
            kind = ICMP_W'($urandom);
            code = ICMP_W'($urandom);
        end
        send_flow(addr, kind, code, last);
    endtask

    // sweep: one whole /24 and a little beyond, noise: unsorted addresses
    task automatic send_scan_event(input bit force_sweep);
        int                pick;
        int                n;
        int                step;
        bit                sweep;
        bit                noise;
        logic [ADDR_W-1:0] addr;
        pick  = $urandom_range(0, 99);
        sweep = force_sweep || pick < 4;
        noise = !sweep && pick >= 92;
        if (sweep)
            n = $urandom_range(256, 300);
        else if (pick < 20)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(4, 24);
        addr = $urandom;
        if ($urandom_range(0, 9) == 0)
            addr[31:8] = 24'hFF_FFFF;
        if (sweep)
        begin
            addr[7:0] = 8'd0;
            sweeps++;
        end
        for (int k = 0; k < n; k++)
        begin
            send_random_flow(addr, k == n - 1);
            if (sweep)
            begin
                addr = addr + 1;
            end
            else if (noise)
            begin
                addr = ($urandom_range(0, 1) == 0) ? ADDR_W'($urandom) : addr ^ 32'd1;
            end
            else
            begin
                step = $urandom_range(0, 99);
                if (step < 50)
                    addr = addr + 1;
                else if (step < 60)
                    addr = addr;
                else if (step < 78)
                    addr = addr + $urandom_range(2, 40);
                else if (step < 92)
                    addr = ((addr & SUBNET_MASK) + 32'h100) | ADDR_W'($urandom_range(0, 3));
                else
                    addr = addr + $urandom_range(512, 1 << 20);
            end
        end
    endtask

    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid && !hold_req) @(posedge clk);
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-flow event
        send_flow(32'h0000_0000, ICMP_ECHO_REQ, ICMP_CODE_NONE, 1'b1);
        // run across the top of the address space into the next /24 by wrap
        send_flow(32'hFFFF_FFFE, ICMP_TIMESTAMP_REQ, ICMP_CODE_NONE, 1'b0);
        send_flow(32'hFFFF_FFFF, ICMP_INFO_REQ, 8'd1, 1'b0);
        send_flow(32'h0000_0000, ICMP_MASK_REQ, ICMP_CODE_NONE, 1'b0);
        send_flow(32'h0000_0005, 8'd0, 8'd0, 1'b0);
        send_flow(32'h0000_0005, 8'd3, 8'd3, 1'b0);
        send_flow(32'h0000_0106, ICMP_ECHO_REQ, 8'd255, 1'b0);
        send_flow(32'h1234_5678, 8'd255, ICMP_CODE_NONE, 1'b1);
        // unsorted extremes
        send_flow(32'hFFFF_FFFF, 8'd255, 8'd255, 1'b0);
        send_flow(32'h0000_0000, 8'd0, 8'd0, 1'b0);
        send_flow(32'h8000_0000, 8'hAA, 8'h55, 1'b0);
        send_flow(32'h5555_5555, 8'h55, 8'hAA, 1'b1);
        // runs recorded only on a jump inside a /24, final run left open
        send_flow(32'h0A00_0001, ICMP_ECHO_REQ, ICMP_CODE_NONE, 1'b0);
        send_flow(32'h0A00_0002, ICMP_ECHO_REQ, ICMP_CODE_NONE, 1'b0);
        send_flow(32'h0A00_0003, ICMP_ECHO_REQ, ICMP_CODE_NONE, 1'b0);
        send_flow(32'h0A00_0007, ICMP_ECHO_REQ, ICMP_CODE_NONE, 1'b0);
        send_flow(32'h0A00_0008, ICMP_ECHO_REQ, ICMP_CODE_NONE, 1'b0);
        send_flow(32'h0A00_0100, ICMP_ECHO_REQ, ICMP_CODE_NONE, 1'b0);
        send_flow(32'h0A00_0101, ICMP_ECHO_REQ, ICMP_CODE_NONE, 1'b0);
        send_flow(32'h0A00_0102, ICMP_ECHO_REQ, ICMP_CODE_NONE, 1'b0);
        send_flow(32'h0A00_0103, ICMP_ECHO_REQ, ICMP_CODE_NONE, 1'b1);

        // hold the result side while short events pile up
        hold_req = 1'b1;
        for (int e = 0; e < 12; e++)
            send_scan_event(1'b0);

        send_scan_event(1'b1);
        while (sent < FLOW_TARGET)
        begin
            if ($urandom_range(0, 19) == 0)
                idle_on = !idle_on;
            send_scan_event(1'b0);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("tb: %0d flows in %0d events, %0d full /24 sweeps, one %0d-cycle output hold",
                 flows_seen, results_seen, sweeps, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/isarm_pkg.sv
rtl/core/isarm_in_reg.sv
rtl/core/isarm_core.sv
rtl/core/isarm_out_reg.sv
rtl/core/icmp_scan_address_run_metrics_unit.sv
tb/icmp_scan_metrics_checker.sv
tb/icmp_scan_address_run_metrics_unit_tb.sv
